// ===== sv/bfb_pkg.sv =====
// Shared types, constants and the ones' complement add helper for the frame builder.
`timescale 1ns / 1ps

package bfb_pkg;

    // Byte counter width: holds the largest supported buffer size itself.
    localparam int CNT_W    = 7;
    // Width of the counter of data byte pairs within one packet.
    localparam int HALF_W   = CNT_W - 1;
    // Entries in the packet descriptor queue.
    localparam int Q_DEPTH  = 2;
    localparam int Q_CNT_W  = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       seq_bit;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] frame_word;
        logic        last_word;
        logic        overflow_flag;
    } t_out_beat;

    // One finished packet waiting to be framed.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             seq;
        logic             dropped;
        logic [15:0]      data_sum;
        logic             bank;
    } t_desc;

    // Byte store write request from the front to the back.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [CNT_W-1:0] idx;
        logic [7:0]       data;
    } t_store_wr;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HDR0,
        BK_HDR1,
        BK_HDR2,
        BK_HEAD,
        BK_RD_A,
        BK_RD_B,
        BK_WORD
    } t_back_state;

    // Ones' complement add with a single end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== sv/bfb_front.sv =====
// Front end: accepts message bytes, stores them and keeps the running data sum.
`timescale 1ns / 1ps

module bfb_front #(
    parameter int MAX_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bfb_pkg::t_in_beat i_in_beat,
    input  logic              i_space,
    output logic              o_in_ready,
    output bfb_pkg::t_store_wr o_wr,
    output logic              o_push,
    output bfb_pkg::t_desc    o_desc
);
    import bfb_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_seq, n_seq;
    logic             r_drop, n_drop;
    logic [15:0]      r_sum, n_sum;
    logic             r_bank, n_bank;

    logic             accept;
    logic             stored;
    logic             seq_eff;
    logic [CNT_W-1:0] count_inc;
    logic             drop_inc;
    logic [15:0]      term;
    logic [15:0]      sum_inc;

    assign o_in_ready = i_space;
    assign accept     = i_in_valid && i_space;
    assign stored     = r_count < CNT_W'(MAX_BYTES);

    // An even byte lands in the middle of a word, an odd byte straddles two words;
    // the pieces never overlap, so each can be added on its own.
    always_comb begin
        if (!r_count[0]) begin
            term = {1'b0, i_in_beat.data_byte, 7'd0};
        end else begin
            term = {i_in_beat.data_byte[0], 8'd0, i_in_beat.data_byte[7:1]};
        end
        seq_eff   = (r_count == '0) ? i_in_beat.seq_bit : r_seq;
        count_inc = stored ? r_count + CNT_W'(1) : r_count;
        drop_inc  = r_drop || !stored;
        sum_inc   = stored ? ones_add(r_sum, term) : r_sum;
    end

    always_comb begin
        n_count = r_count;
        n_seq   = r_seq;
        n_drop  = r_drop;
        n_sum   = r_sum;
        n_bank  = r_bank;
        if (accept) begin
            if (i_in_beat.last_byte) begin
                n_count = '0;
                n_seq   = 1'b0;
                n_drop  = 1'b0;
                n_sum   = '0;
                n_bank  = !r_bank;
            end else begin
                n_count = count_inc;
                n_seq   = seq_eff;
                n_drop  = drop_inc;
                n_sum   = sum_inc;
            end
        end
    end

    always_comb begin
        o_wr.en         = accept && stored;
        o_wr.bank       = r_bank;
        o_wr.idx        = r_count;
        o_wr.data       = i_in_beat.data_byte;
        o_push          = accept && i_in_beat.last_byte;
        o_desc.count    = count_inc;
        o_desc.seq      = seq_eff;
        o_desc.dropped  = drop_inc;
        o_desc.data_sum = sum_inc;
        o_desc.bank     = r_bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seq   <= 1'b0;
            r_drop  <= 1'b0;
            r_sum   <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_seq   <= n_seq;
            r_drop  <= n_drop;
            r_sum   <= n_sum;
            r_bank  <= n_bank;
        end
    end

endmodule

// ===== sv/bfb_queue.sv =====
// Two-entry queue of finished packet descriptors between front and back.
`timescale 1ns / 1ps

module bfb_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  bfb_pkg::t_desc                i_desc,
    input  logic                          i_pop,
    output logic                          o_valid,
    output bfb_pkg::t_desc                o_desc,
    output logic [bfb_pkg::Q_CNT_W-1:0]   o_count
);
    import bfb_pkg::*;

    t_desc              r_entry [Q_DEPTH];
    logic               r_wr_ptr, n_wr_ptr;
    logic               r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = r_count != '0;
    assign o_desc  = r_entry[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = i_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + Q_CNT_W'(i_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

endmodule

// ===== sv/bfb_back.sv =====
// Back end: double-banked byte store, checksum finish and frame word sequencer.
`timescale 1ns / 1ps

module bfb_back #(
    parameter int MAX_BYTES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfb_pkg::t_store_wr i_wr,
    input  logic               i_desc_valid,
    input  bfb_pkg::t_desc     i_desc,
    output logic               o_pop,
    output logic               o_busy,
    input  logic [15:0]        i_port_number,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bfb_pkg::t_out_beat o_out_beat
);
    import bfb_pkg::*;

    localparam int DEPTH  = 2 * MAX_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;

    t_back_state       r_state, n_state;
    t_desc             r_desc;
    logic [15:0]       r_sum;
    logic [1:0]        r_widx;
    logic [HALF_W-1:0] r_j;
    logic              r_prev;
    logic [7:0]        r_byte_a;

    logic              r_out_valid;
    t_out_beat         r_out_beat;

    logic              out_free;
    logic              rd_en;
    logic [CNT_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  idx_a;
    logic [CNT_W-1:0]  idx_b;
    logic              a_ok;
    logic              b_ok;
    logic [7:0]        byte_b;
    logic [15:0]       len;
    logic              word_load;
    logic [15:0]       word;
    logic              word_last;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    function automatic logic [ADDR_W-1:0] bank_addr(input logic bank,
                                                    input logic [CNT_W-1:0] idx);
        return bank ? ADDR_W'(MAX_BYTES) + ADDR_W'(idx) : ADDR_W'(idx);
    endfunction

    assign out_free = !r_out_valid || i_out_ready;
    assign idx_a    = {r_j, 1'b0};
    assign idx_b    = {r_j, 1'b1};
    assign a_ok     = idx_a < r_desc.count;
    assign b_ok     = idx_b < r_desc.count;
    assign byte_b   = b_ok ? r_rd_data : 8'd0;
    assign len      = {6'd0, r_desc.count, 3'd0};
    assign wr_addr  = bank_addr(i_wr.bank, i_wr.idx);
    assign rd_addr  = bank_addr(r_desc.bank, rd_idx);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_desc_valid) begin
                    n_state = BK_HDR0;
                end
            end
            BK_HDR0: n_state = BK_HDR1;
            BK_HDR1: n_state = BK_HDR2;
            BK_HDR2: n_state = BK_HEAD;
            BK_HEAD: begin
                if (out_free && r_widx == 2'd2) begin
                    n_state = BK_RD_A;
                end
            end
            BK_RD_A: n_state = BK_RD_B;
            BK_RD_B: n_state = BK_WORD;
            BK_WORD: begin
                if (out_free) begin
                    n_state = word_last ? BK_IDLE : BK_RD_A;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_pop     = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = idx_a;
        word_load = 1'b0;
        word      = '0;
        word_last = 1'b0;
        unique case (r_state)
            BK_IDLE: o_pop = i_desc_valid;
            BK_HDR0, BK_HDR1, BK_HDR2: begin
            end
            BK_HEAD: begin
                word_load = out_free;
                case (r_widx)
                    2'd0:    word = i_port_number;
                    2'd1:    word = {r_desc.seq, len[15:1]};
                    default: word = {len[0], ~r_sum[15:1]};
                endcase
            end
            BK_RD_A: begin
                rd_en  = a_ok;
                rd_idx = idx_a;
            end
            BK_RD_B: begin
                rd_en  = b_ok;
                rd_idx = idx_b;
            end
            BK_WORD: begin
                word_load = out_free;
                word      = {r_prev, r_byte_a, byte_b[7:1]};
                word_last = r_j == r_desc.count[CNT_W-1:1];
            end
            default: begin
            end
        endcase
    end

    assign o_busy = r_state != BK_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (word_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc  <= i_desc;
            r_sum   <= i_desc.data_sum;
            r_widx  <= 2'd0;
        end
        unique case (r_state)
            BK_HDR0: r_sum <= ones_add(r_sum, i_port_number);
            BK_HDR1: r_sum <= ones_add(r_sum, {r_desc.seq, len[15:1]});
            BK_HDR2: r_sum <= ones_add(r_sum, {len[0], 15'd0});
            BK_HEAD: begin
                if (out_free) begin
                    r_widx <= r_widx + 2'd1;
                    // The low checksum bit opens the first data word.
                    r_prev <= ~r_sum[0];
                    r_j    <= '0;
                end
            end
            BK_RD_B: r_byte_a <= a_ok ? r_rd_data : 8'd0;
            BK_WORD: begin
                if (out_free) begin
                    r_prev <= byte_b[0];
                    r_j    <= r_j + HALF_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (word_load) begin
            r_out_beat.frame_word    <= word;
            r_out_beat.last_word     <= word_last;
            r_out_beat.overflow_flag <= r_desc.dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[wr_addr] <= i_wr.data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== sv/bitpacked_frame_builder_checksum_unit.sv =====
// Top level of the bit-packed frame builder with a 16-bit ones' complement checksum.
// Input: one byte per cycle, stalled while a finished packet waits for a busy back end.
// Output: a frame of n bytes is 4 + n/2 (rounded down) words; the back end takes the
// packet, adds the header fields into the sum, then sends each header word and reads two
// bytes for each data word.
// Reset (synchronous, active low) clears counters, queue, sequencer and port register.
`timescale 1ns / 1ps

module bitpacked_frame_builder_checksum_unit #(
    parameter int MAX_BYTES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bfb_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bfb_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);
    import bfb_pkg::*;

    // The port number register must be written by the user only while the block is
    // idle, which the block does not enforce, so the back end reads it directly while framing.
    logic [15:0]        r_port_number;

    t_store_wr          wr;
    logic               push;
    t_desc              push_desc;
    logic               q_valid;
    t_desc              q_desc;
    logic [Q_CNT_W-1:0] q_count;
    logic               pop;
    logic               back_busy;
    logic               space;

    // Each finished packet owns one bank of the byte store until its frame has
    // gone out. With both banks held (queued or in the back end) the front
    // must wait; otherwise it keeps loading the free bank.
    assign space = (q_count + Q_CNT_W'(back_busy)) < Q_CNT_W'(Q_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_number <= '0;
        end else if (i_cfg_we) begin
            r_port_number <= i_cfg_wdata;
        end
    end

    bfb_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .i_space    (space),
        .o_in_ready (o_in_ready),
        .o_wr       (wr),
        .o_push     (push),
        .o_desc     (push_desc)
    );

    bfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .o_count (q_count)
    );

    bfb_back #(
        .MAX_BYTES (MAX_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (wr),
        .i_desc_valid  (q_valid),
        .i_desc        (q_desc),
        .o_pop         (pop),
        .o_busy        (back_busy),
        .i_port_number (r_port_number),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_beat    (o_out_beat)
    );

endmodule

// ===== dv/tb_bitpacked_frame_builder_checksum_unit.sv =====
// Self-checking testbench for the bit-packed frame builder with a ones' complement checksum.
`timescale 1ns / 1ps

module tb_bitpacked_frame_builder_checksum_unit;
    import bfb_pkg::*;

    localparam int MAX_BYTES     = 64;
    // The header holds port, sequence bit, length and checksum: 16 + 1 + 16 + 16 bits.
    localparam int HDR_BITS      = 49;
    // The checksum field starts right after port, sequence bit and length.
    localparam int CSUM_POS      = 33;
    localparam int FRAME_WORDS   = (HDR_BITS + 8 * MAX_BYTES + 15) / 16;
    localparam int FRAME_BITS    = 16 * FRAME_WORDS;
    localparam int RANDOM_BYTES  = 376;
    localparam int PHASES        = 4;
    localparam int GAP_MAX       = 12;
    // The receiver holds off this long once, so that two finished packets queue up inside
    // the block and its input stalls.
    localparam int LONG_HOLD     = 400;
    // Cycles allowed after the last expected word before a port write or the final verdict.
    localparam int SETTLE_CYCLES = 16;
    // A correct run never goes this long without a beat on either side: the worst case is
    // the long receiver hold plus a full frame of stalled words.
    localparam int WATCHDOG_LIMIT = 2000;

    // Predicts the frame of each packet and checks the output beats against it.
    class frame_checker;
        logic [15:0] port_reg;
        logic [7:0]  msg_bytes [MAX_BYTES];
        int unsigned stored;
        logic        first_seq;
        logic        lost_bytes;
        t_out_beat   expected_words [$];
        int          errors;
        int          words_seen;
        int          frames_built;
        int          lossy_frames;

        function new();
            port_reg     = '0;
            stored       = 0;
            first_seq    = 1'b0;
            lost_bytes   = 1'b0;
            errors       = 0;
            words_seen   = 0;
            frames_built = 0;
            lossy_frames = 0;
        endfunction

        function void set_port(input logic [15:0] value);
            port_reg = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Takes one accepted input beat; on the last byte of a packet the whole frame is
        // built and its words are queued as expectations.
        function void note_byte(input t_in_beat beat);
            logic [FRAME_BITS-1:0] bits;
            int unsigned           nwords;
            int unsigned           sum;
            t_out_beat             word;
            if (stored == 0) begin
                first_seq = beat.seq_bit;
            end
            if (stored < MAX_BYTES) begin
                msg_bytes[stored] = beat.data_byte;
                stored++;
            end else begin
                lost_bytes = 1'b1;
            end
            if (!beat.last_byte) begin
                return;
            end

            // Frame bit 0 sits at the top of the vector; the checksum field starts as zero.
            bits = '0;
            bits[FRAME_BITS-1 -: HDR_BITS] = {port_reg, first_seq, 16'(8 * stored), 16'h0000};
            for (int k = 0; k < int'(stored); k++) begin
                bits[FRAME_BITS-1-HDR_BITS-8*k -: 8] = msg_bytes[k];
            end
            nwords = (HDR_BITS + 8 * stored + 15) / 16;

            // End-around carry sum over every word of the frame.
            sum = 0;
            for (int k = 0; k < int'(nwords); k++) begin
                sum = sum + 32'(bits[FRAME_BITS-1-16*k -: 16]);
                sum = (sum >> 16) + (sum & 32'h0000_ffff);
            end
            bits[FRAME_BITS-1-CSUM_POS -: 16] = ~sum[15:0];

            for (int k = 0; k < int'(nwords); k++) begin
                word.frame_word    = bits[FRAME_BITS-1-16*k -: 16];
                word.last_word     = (k == int'(nwords) - 1);
                word.overflow_flag = lost_bytes;
                expected_words.push_back(word);
            end
            frames_built++;
            if (lost_bytes) begin
                lossy_frames++;
            end
            stored     = 0;
            first_seq  = 1'b0;
            lost_bytes = 1'b0;
        endfunction

        // Compares one accepted output beat with the oldest expected word.
        function void check_word(input t_out_beat got);
            t_out_beat want;
            words_seen++;
            if (expected_words.size() == 0) begin
                $error("frame_word: no word expected, got %h", got.frame_word);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.frame_word !== want.frame_word) begin
                $error("frame_word: expected %h, got %h", want.frame_word, got.frame_word);
                errors++;
            end
            if (got.last_word !== want.last_word) begin
                $error("last_word: expected %b, got %b", want.last_word, got.last_word);
                errors++;
            end
            if (got.overflow_flag !== want.overflow_flag) begin
                $error("overflow_flag: expected %b, got %b",
                       want.overflow_flag, got.overflow_flag);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    t_in_beat    in_beat     = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    t_out_beat   out_beat;
    logic        cfg_we      = 1'b0;
    logic [15:0] cfg_wdata   = '0;

    frame_checker sb;
    bit          tx_busy       = 1'b1;
    bit          rx_busy       = 1'b1;
    bit          long_hold_req = 1'b0;
    bit          long_hold_hit = 1'b0;
    int          bytes_sent    = 0;
    int          port_writes   = 0;

    always #1 i_clk = ~i_clk;

    bitpacked_frame_builder_checksum_unit #(
        .MAX_BYTES (MAX_BYTES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Offers one input beat, after a random gap while tx_busy is set, and returns right after the edge that
    // accepted it. Ready is read just after the edge, so it still holds its pre-edge value.
    task automatic send_byte(input logic [7:0] data, input logic seq, input logic last);
        int gap;
        gap = tx_busy ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid          <= 1'b1;
        in_beat.data_byte <= data;
        in_beat.seq_bit   <= seq;
        in_beat.last_byte <= last;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sb.note_byte(t_in_beat'{data, seq, last});
        bytes_sent++;
    endtask

    // Sends one packet of random bytes. The sequence bit is random on every byte, so a
    // block that samples it anywhere but on the first byte shows up.
    task automatic send_packet(input int len);
        tx_busy = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++) begin
            send_byte(8'($urandom), 1'($urandom), k == len - 1);
        end
    endtask

    // The port register is only written with the block idle: every packet has ended,
    // every word has drained and the back end has had time to settle.
    task automatic write_port(input logic [15:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_port(value);
        port_writes++;
    endtask

    // Receiver: stalls a random number of cycles before each word, with stretches where it
    // never stalls, and once holds off for a long time when asked to.
    initial begin : receiver
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
                long_hold_hit = 1'b1;
            end
            stall = rx_busy ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            sb.check_word(out_beat);
            if ($urandom_range(0, 31) == 0) begin
                rx_busy = ~rx_busy;
            end
        end
    end

    // Ends the run if neither side moves a beat for too long, which also catches words
    // that never arrive at the end.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL bitpacked_frame_builder_checksum_unit");
        $finish;
    end

    initial begin : stimulus
        int budget;
        int len;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The first frame uses the port value left by reset.
        send_byte(8'h00, 1'b0, 1'b1);
        write_port(16'hffff);
        send_byte(8'hff, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        // Later sequence bits differ from the first one and must be ignored.
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h55, 1'b1, 1'b1);
        write_port(16'h0000);
        send_byte(8'haa, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b0);
        send_byte(8'h7f, 1'b0, 1'b1);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h02, 1'b1, 1'b0);
        send_byte(8'hfe, 1'b0, 1'b0);
        send_byte(8'h40, 1'b1, 1'b0);
        send_byte(8'hc3, 1'b1, 1'b1);

        // Random part in phases, each under its own port setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1:       write_port(16'h8000);
                3:       write_port(16'h0001);
                default: write_port(16'($urandom));
            endcase
            budget = bytes_sent + RANDOM_BYTES / PHASES;
            // A packet that exactly fills the buffer, and one that spills past it.
            if (ph == 0) begin
                send_packet(MAX_BYTES);
            end else if (ph == 2) begin
                send_packet(MAX_BYTES + $urandom_range(1, 4));
            end
            // The receiver stalls for a long stretch while packets keep coming.
            if (ph == 1) begin
                long_hold_req = 1'b1;
            end
            while (bytes_sent < budget) begin
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(MAX_BYTES - 4, MAX_BYTES + 6);
                end else begin
                    len = $urandom_range(1, 24);
                end
                send_packet(len);
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes in %0d packets (%0d past the buffer size), %0d port settings.",
                 bytes_sent, sb.frames_built, sb.lossy_frames, port_writes + 1);
        $display("Checked %0d frame words; long receiver hold %s.",
                 sb.words_seen, long_hold_hit ? "done" : "not reached");
        if (sb.errors == 0) begin
            $display("PASS bitpacked_frame_builder_checksum_unit");
        end else begin
            $display("FAIL bitpacked_frame_builder_checksum_unit");
        end
        $finish;
    end

endmodule

// ===== bitpacked_frame_builder_checksum_unit.f =====
sv/bfb_pkg.sv
sv/bfb_front.sv
sv/bfb_queue.sv
sv/bfb_back.sv
sv/bitpacked_frame_builder_checksum_unit.sv
dv/tb_bitpacked_frame_builder_checksum_unit.sv
